/* rtl/core/assert_macros.svh */
// Assertion macros used by the checker file of the heartbeat supervisor.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NHS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define NHS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/nhs_pkg.sv */
// Package for the node heartbeat supervisor: payload structs, codes, defaults.
// No dependencies.
`default_nettype none

package nhs_pkg;

    localparam int ELAPSED_WIDTH_DEF = 17;

    localparam int TIMEOUT_W = 16;
    localparam int NODE_ID_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETUP_TIMEOUT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HB_TIMEOUT = 2'd2;

    localparam logic [NODE_ID_W-1:0] NODE_ID_RST = 7'd1;
    localparam logic [TIMEOUT_W-1:0] SETUP_TIMEOUT_RST = 16'd2000;
    localparam logic [TIMEOUT_W-1:0] HB_TIMEOUT_RST = 16'd5000;

    localparam logic [10:0] HB_BASE_ID = 11'h700;
    localparam logic [7:0] HB_BOOT = 8'h00;
    localparam logic [7:0] HB_OPERATIONAL = 8'h05;

    // Phase codes
    localparam logic [1:0] PHASE_INIT = 2'd0;
    localparam logic [1:0] PHASE_HB_SETUP = 2'd1;
    localparam logic [1:0] PHASE_VEL_SETUP = 2'd2;
    localparam logic [1:0] PHASE_AVAILABLE = 2'd3;

    // Action codes
    localparam logic [1:0] ACT_NONE = 2'd0;
    localparam logic [1:0] ACT_WRITE_HB_PERIOD = 2'd1;
    localparam logic [1:0] ACT_VEL_SETUP = 2'd2;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [10:0] frame_id;
        logic [3:0]  frame_length;
        logic [7:0]  first_byte;
    } in_item_t;

    typedef struct packed {
        logic [1:0] action;
        logic [1:0] phase_out;
        logic       link_up_out;
    } out_item_t;

    typedef struct packed {
        logic [NODE_ID_W-1:0] node_id;
        logic [TIMEOUT_W-1:0] setup_timeout_ms;
        logic [TIMEOUT_W-1:0] heartbeat_timeout_ms;
    } cfg_t;

endpackage

`default_nettype wire

/* rtl/core/nhs_core.sv */
// Supervision state machine and saturating elapsed-time counters.
// Depends on nhs_pkg.
`default_nettype none

module nhs_core #(
    parameter int ELAPSED_WIDTH = nhs_pkg::ELAPSED_WIDTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              item_accept,
    input  wire nhs_pkg::in_item_t item,
    input  wire nhs_pkg::cfg_t     cfg,
    output nhs_pkg::out_item_t     result
);
    import nhs_pkg::*;

    localparam int CMP_W = (ELAPSED_WIDTH > TIMEOUT_W) ? ELAPSED_WIDTH : TIMEOUT_W;

    typedef enum logic [1:0] {
        ST_INIT      = PHASE_INIT,
        ST_HB_SETUP  = PHASE_HB_SETUP,
        ST_VEL_SETUP = PHASE_VEL_SETUP,
        ST_AVAILABLE = PHASE_AVAILABLE
    } phase_t;

    phase_t                   phase_reg, phase_next;
    logic [ELAPSED_WIDTH-1:0] setup_elapsed_reg, setup_elapsed_next;
    logic [ELAPSED_WIDTH-1:0] hb_elapsed_reg, hb_elapsed_next;
    logic                     link_up_reg, link_up_next;
    logic [1:0]               action;
    logic                     own;
    logic                     one_byte;

    always_comb begin
        phase_next = phase_reg;
        setup_elapsed_next = setup_elapsed_reg;
        hb_elapsed_next = hb_elapsed_reg;
        link_up_next = link_up_reg;
        action = ACT_NONE;
        own = (item.cmd == CMD_FRAME)
            && (item.frame_id == (HB_BASE_ID + {4'b0000, cfg.node_id}));
        one_byte = (item.frame_length == 4'd1);

        // ticks advance both counters, holding at all ones
        if (item.cmd != CMD_FRAME) begin
            if (!(&setup_elapsed_next))
                setup_elapsed_next = setup_elapsed_next + ELAPSED_WIDTH'(1);
            if (!(&hb_elapsed_next))
                hb_elapsed_next = hb_elapsed_next + ELAPSED_WIDTH'(1);
        end

        // boot-up heartbeat forces velocity setup before the phase logic
        if (own && one_byte && item.first_byte == HB_BOOT) begin
            setup_elapsed_next = '0;
            phase_next = ST_VEL_SETUP;
        end

        case (phase_next)
            ST_INIT: begin
                phase_next = ST_HB_SETUP;
            end
            ST_HB_SETUP: begin
                action = ACT_WRITE_HB_PERIOD;
                setup_elapsed_next = '0;
                phase_next = ST_VEL_SETUP;
            end
            ST_VEL_SETUP: begin
                if (CMP_W'(setup_elapsed_next) > CMP_W'(cfg.setup_timeout_ms)) begin
                    phase_next = ST_HB_SETUP;
                end else if (own && one_byte) begin
                    if (item.first_byte != HB_OPERATIONAL)
                        action = ACT_VEL_SETUP;
                    hb_elapsed_next = '0;
                    link_up_next = 1'b1;
                    phase_next = ST_AVAILABLE;
                end
            end
            ST_AVAILABLE: begin
                if (own && item.first_byte == HB_OPERATIONAL)
                    hb_elapsed_next = '0;
                link_up_next = !(CMP_W'(hb_elapsed_next) > CMP_W'(cfg.heartbeat_timeout_ms));
                if (!link_up_next)
                    phase_next = ST_HB_SETUP;
            end
            default: begin
                phase_next = ST_INIT;
            end
        endcase

        result.action = action;
        result.phase_out = phase_next;
        result.link_up_out = link_up_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ST_INIT;
            setup_elapsed_reg <= '0;
            hb_elapsed_reg <= '0;
            link_up_reg <= 1'b0;
        end else if (item_accept) begin
            phase_reg <= phase_next;
            setup_elapsed_reg <= setup_elapsed_next;
            hb_elapsed_reg <= hb_elapsed_next;
            link_up_reg <= link_up_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/node_heartbeat_supervisor_top.sv */
// Top level of the node heartbeat supervisor: config registers, result register.
// Depends on nhs_pkg and nhs_core.
//
//   channel   ports            direction   payload
//   input     s_valid/s_ready  in          nhs_pkg::in_item_t (tick or frame)
//   result    m_valid/m_ready  out         nhs_pkg::out_item_t
//   config    cfg_wr_en        in          cfg_index, cfg_wdata
//
// One item per clock while s_ready is high; each accepted item gives exactly one
// result, which appears in the next cycle. The state update is a single pass of
// compare and counter logic between the state registers and the result register.
// s_ready is high while the result register is empty or being drained.
// aresetn (synchronous, active low) restores phase init, cleared counters,
// link down and the register defaults.
`default_nettype none

module node_heartbeat_supervisor_top #(
    parameter int ELAPSED_WIDTH = nhs_pkg::ELAPSED_WIDTH_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire nhs_pkg::in_item_t              s_data,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output nhs_pkg::out_item_t                  m_data,
    input  wire logic                           cfg_wr_en,
    input  wire logic [nhs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [nhs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import nhs_pkg::*;

    cfg_t      cfg_reg;
    out_item_t result;
    out_item_t m_data_reg;
    logic      m_valid_reg;
    logic      accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.node_id <= NODE_ID_RST;
            cfg_reg.setup_timeout_ms <= SETUP_TIMEOUT_RST;
            cfg_reg.heartbeat_timeout_ms <= HB_TIMEOUT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NODE_ID:       cfg_reg.node_id <= cfg_wdata[NODE_ID_W-1:0];
                CFG_SETUP_TIMEOUT: cfg_reg.setup_timeout_ms <= cfg_wdata;
                CFG_HB_TIMEOUT:    cfg_reg.heartbeat_timeout_ms <= cfg_wdata;
                default: ;
            endcase
        end
    end

    nhs_core #(
        .ELAPSED_WIDTH(ELAPSED_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_accept (accept),
        .item        (s_data),
        .cfg         (cfg_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/nhs_checker.sv */
// Port-level checks for the node heartbeat supervisor, bound to its top level.
// Depends on nhs_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module nhs_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire nhs_pkg::out_item_t m_data
);
    import nhs_pkg::*;

    // a stalled result keeps its value
    `NHS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")

    // every input transfer yields a result on the next cycle
    `NHS_ASSERT_NEXT(a_one_result, aclk, aresetn, s_valid && s_ready, m_valid, "no result after input transfer")

    // no new input while a result is stuck
    `NHS_ASSERT_NOW(a_no_overrun, aclk, aresetn, m_valid && !m_ready, !s_ready, "input taken over a stalled result")

    // period write only leaves heartbeat setup for velocity setup
    `NHS_ASSERT_NOW(a_hb_write_phase, aclk, aresetn, m_valid && m_data.action == ACT_WRITE_HB_PERIOD, m_data.phase_out == PHASE_VEL_SETUP, "period write outside velocity setup")

    // velocity setup request comes with the link up in available
    `NHS_ASSERT_NOW(a_vel_setup_link, aclk, aresetn, m_valid && m_data.action == ACT_VEL_SETUP, m_data.phase_out == PHASE_AVAILABLE && m_data.link_up_out, "velocity setup without link")

endmodule

bind node_heartbeat_supervisor_top nhs_checker u_nhs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
